[rtl/cbt_pkg.sv]
package cbt_pkg;

	// field widths of the item and the table entry
	localparam int PHI_W   = 16;
	localparam int THETA_W = 15;
	localparam int SLOT_W  = 9;
	localparam int COUNT_W = 10;

	// entry count register
	localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd361;
	localparam int                 MIN_COUNT   = 2;

	// item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// input transaction
	typedef struct packed {
		logic                      kind;
		logic [SLOT_W-1:0]         entry_index;
		logic signed [PHI_W-1:0]   phi_value;
		logic [THETA_W-1:0]        theta_value;
	} item_t;

	// output transaction
	typedef struct packed {
		logic forbidden;
		logic exact_match;
	} result_t;

	// one boundary point in the table memory
	typedef struct packed {
		logic signed [PHI_W-1:0] phi;
		logic [THETA_W-1:0]      theta;
	} entry_t;

endpackage

[rtl/cbt_table_ram.sv]
module cbt_table_ram #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  cbt_pkg::entry_t       wr_data,
	input  logic [AW-1:0]         rd_addr,
	output cbt_pkg::entry_t       rd_data
);

	cbt_pkg::entry_t mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/cbt_search.sv]
module cbt_search #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  cbt_pkg::item_t        item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output cbt_pkg::result_t      result,
	input  logic [AW-1:0]         last_idx,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output cbt_pkg::entry_t       wr_data,
	output logic [AW-1:0]         rd_addr,
	input  cbt_pkg::entry_t       rd_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_LAST,
		ST_CHK_LAST,
		ST_PROBE,
		ST_DONE
	} state_t;

	state_t                              state_q;
	logic signed [cbt_pkg::PHI_W-1:0]    phi_q;
	logic [cbt_pkg::THETA_W-1:0]         theta_q;
	logic [cbt_pkg::THETA_W-1:0]         theta_lo_q;
	logic [cbt_pkg::THETA_W-1:0]         theta_hi_q;
	logic                                below_q;
	logic                                exact_q;
	logic                                single_q;
	logic [AW-1:0]                       lo_q;
	logic [AW-1:0]                       hi_q;
	logic [AW-1:0]                       mid_q;

	logic                                accept;
	logic                                probe_eq;
	logic                                probe_lt;
	logic [AW-1:0]                       lo_nx;
	logic [AW-1:0]                       hi_nx;
	logic [AW-1:0]                       mid_nx;
	logic                                more;
	logic [cbt_pkg::THETA_W:0]           theta_sum;
	logic                                forbid;
	logic                                out_free;

	// input handshake and table writes
	always_comb begin
		accept     = item_valid && (state_q == ST_IDLE);
		item_stall = (state_q != ST_IDLE);
		wr_en      = accept && (item.kind == cbt_pkg::KIND_WRITE)
			&& (32'(item.entry_index) < DEPTH);
		wr_addr    = AW'(item.entry_index);
		wr_data    = '{phi: item.phi_value, theta: item.theta_value};
	end

	// interval update and next probe address
	always_comb begin
		probe_eq = (rd_data.phi == phi_q);
		probe_lt = (rd_data.phi < phi_q);
		lo_nx    = lo_q;
		hi_nx    = hi_q;
		if (state_q == ST_CHK_LAST) begin
			lo_nx = '0;
			hi_nx = last_idx;
		end else if (probe_lt) begin
			lo_nx = mid_q;
		end else begin
			hi_nx = mid_q;
		end
		more   = (hi_nx - lo_nx) > AW'(1);
		mid_nx = AW'(({1'b0, lo_nx} + {1'b0, hi_nx}) >> 1);
		case (state_q)
			ST_IDLE:    rd_addr = '0;
			ST_RD_LAST: rd_addr = last_idx;
			default:    rd_addr = mid_nx;
		endcase
	end

	// threshold compare: a single entry against theta, else the mean taken as a sum against twice theta
	always_comb begin
		theta_sum = {1'b0, theta_lo_q} + {1'b0, theta_hi_q};
		if (single_q) begin
			forbid = (theta_lo_q <= theta_q);
		end else begin
			forbid = (theta_sum <= {theta_q, 1'b0});
		end
		out_free = !result_valid || !result_stall;
	end

	// search sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (item.kind == cbt_pkg::KIND_QUERY)) begin
						phi_q   <= item.phi_value;
						theta_q <= item.theta_value;
						state_q <= ST_RD_LAST;
					end
				end
				ST_RD_LAST: begin
					below_q    <= (phi_q <= rd_data.phi);
					exact_q    <= probe_eq;
					theta_lo_q <= rd_data.theta;
					state_q    <= ST_CHK_LAST;
				end
				ST_CHK_LAST: begin
					if (below_q) begin
						single_q <= 1'b1;
						state_q  <= ST_DONE;
					end else if (phi_q >= rd_data.phi) begin
						exact_q    <= probe_eq;
						theta_lo_q <= rd_data.theta;
						single_q   <= 1'b1;
						state_q    <= ST_DONE;
					end else begin
						exact_q    <= 1'b0;
						single_q   <= 1'b0;
						theta_hi_q <= rd_data.theta;
						lo_q       <= lo_nx;
						hi_q       <= hi_nx;
						mid_q      <= mid_nx;
						state_q    <= more ? ST_PROBE : ST_DONE;
					end
				end
				ST_PROBE: begin
					if (probe_eq) begin
						exact_q    <= 1'b1;
						single_q   <= 1'b1;
						theta_lo_q <= rd_data.theta;
						state_q    <= ST_DONE;
					end else begin
						if (probe_lt) begin
							theta_lo_q <= rd_data.theta;
						end else begin
							theta_hi_q <= rd_data.theta;
						end
						lo_q    <= lo_nx;
						hi_q    <= hi_nx;
						mid_q   <= mid_nx;
						state_q <= more ? ST_PROBE : ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						result       <= '{forbidden: forbid, exact_match: exact_q};
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/cone_boundary_table_check_top.sv]
// channel  | direction | payload            | handshake
// item     | in        | cbt_pkg::item_t    | item_valid / item_stall
// result   | out       | cbt_pkg::result_t  | result_valid / result_stall
// count    | in        | 10-bit entry count | count_we / count_wdata
//
// a write transaction leaves the input free for the next item and gives no result
// a query reads entry 0 and the last valid entry, then the table memory once per
// binary search probe, one read port
// reset sets the entry count to 361; the table memory is not cleared
// a result waits in the output register while the next item is accepted
module cone_boundary_table_check_top #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  cbt_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output cbt_pkg::result_t              result,
	input  logic                          count_we,
	input  logic [cbt_pkg::COUNT_W-1:0]   count_wdata
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [cbt_pkg::COUNT_W-1:0] count_q;
	logic [31:0]                 count_ext;
	logic [AW-1:0]               last_idx;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	cbt_pkg::entry_t             wr_data;
	logic [AW-1:0]               rd_addr;
	cbt_pkg::entry_t             rd_data;

	// entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= cbt_pkg::COUNT_RESET;
		end else if (count_we) begin
			count_q <= count_wdata;
		end
	end

	// clamp the count to the table and take the last valid index
	always_comb begin
		count_ext = 32'(count_q);
		if (count_ext < cbt_pkg::MIN_COUNT) begin
			last_idx = AW'(cbt_pkg::MIN_COUNT - 1);
		end else if (count_ext > TABLE_DEPTH) begin
			last_idx = AW'(TABLE_DEPTH - 1);
		end else begin
			last_idx = AW'(count_ext - 32'd1);
		end
	end

	cbt_search #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.last_idx     (last_idx),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	cbt_table_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

[rtl/cbt_checker.sv]
module cbt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_stall,
	input cbt_pkg::item_t                item,
	input logic                          result_valid,
	input logic                          result_stall,
	input cbt_pkg::result_t              result
);

	// a write transaction frees the input at once
	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.kind == cbt_pkg::KIND_WRITE) |=> !item_stall)
		else $error("input stalled after a write transaction");

	// a query keeps the input stalled while the search runs
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.kind == cbt_pkg::KIND_QUERY) |=> item_stall)
		else $error("input not stalled after a query transaction");

	// a query accepted while no result waits gives no result before its search has run
	a_query_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.kind == cbt_pkg::KIND_QUERY)
		&& !result_valid |=> !result_valid ##1 !result_valid)
		else $error("result appeared too early after a query");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

endmodule

bind cone_boundary_table_check_top cbt_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

[tb/cone_boundary_table_check_top_tb.sv]
module cone_boundary_table_check_top_tb;

	localparam int DEPTH       = 512;
	localparam int ANGLE_MAX   = 23040;
	localparam int DRAIN_WAIT  = 32;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 14;
	localparam int PLAN_LEN    = 11;
	localparam int SCRAMBLE_PH = 10;
	localparam int RANDOM_PH   = 8;
	localparam int COUNT_PLAN [PLAN_LEN] = '{0, 1, 2, 3, 512, 1023, 361, 600, 0, 100, 16};

	typedef struct {
		cbt_pkg::item_t txn;
		bit             drain;
	} pending_t;

	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        item_valid   = 1'b0;
	logic                        item_stall;
	cbt_pkg::item_t              item         = '0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	cbt_pkg::result_t            result;
	logic                        count_we     = 1'b0;
	logic [cbt_pkg::COUNT_W-1:0] count_wdata  = cbt_pkg::COUNT_RESET;

	// predictor copy of the table and the count register
	logic signed [cbt_pkg::PHI_W-1:0] lut_phi   [0:DEPTH-1];
	logic [cbt_pkg::THETA_W-1:0]      lut_theta [0:DEPTH-1];
	logic [cbt_pkg::COUNT_W-1:0]      cfg_count = cbt_pkg::COUNT_RESET;

	// table as the stimulus generator sees it, ahead of the block
	int gen_phi   [0:DEPTH-1];
	int gen_theta [0:DEPTH-1];
	int gen_n = 361;

	pending_t         pending_items [$];
	cbt_pkg::result_t expected_verdicts [$];

	bit       calm_phase  = 1'b0;
	bit       order_free  = 1'b0;
	int       item_gap    = 0;
	int       stall_left  = 0;
	int       mon_wait;
	int       quiet_cycles = 0;
	int       error_count = 0;
	int       queries_sent = 0;
	int       writes_done = 0;
	int       verdicts_seen = 0;
	int       exact_seen = 0;
	int       forbid_seen = 0;
	int       count_writes = 0;
	logic     drv_valid_nxt;
	pending_t drv_pick;

	cone_boundary_table_check_top #(
		.TABLE_DEPTH(DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.count_we    (count_we),
		.count_wdata (count_wdata)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// interval lookup over the predictor table
	function automatic cbt_pkg::result_t lookup_boundary(
		input logic signed [cbt_pkg::PHI_W-1:0] qphi,
		input logic [cbt_pkg::THETA_W-1:0]      qtheta
	);
		int unsigned      n;
		int unsigned      lo;
		int unsigned      hi;
		int unsigned      mid;
		logic             hit;
		logic [16:0]      tsum;
		cbt_pkg::result_t r;
		n = cfg_count;
		if (n < cbt_pkg::MIN_COUNT) n = cbt_pkg::MIN_COUNT;
		if (n > DEPTH) n = DEPTH;
		lo = 0;
		hi = n - 1;
		hit = 1'b0;
		if (qphi <= lut_phi[lo]) begin
			hit = (qphi == lut_phi[lo]);
			hi = lo;
		end else if (qphi >= lut_phi[hi]) begin
			hit = (qphi == lut_phi[hi]);
			lo = hi;
		end else begin
			while (!hit && (hi - lo > 1)) begin
				mid = (lo + hi) >> 1;
				if (lut_phi[mid] == qphi) begin
					hit = 1'b1;
					lo = mid;
					hi = mid;
				end else if (lut_phi[mid] < qphi) begin
					lo = mid;
				end else begin
					hi = mid;
				end
			end
		end
		if (lo == hi) begin
			r.forbidden = (lut_theta[lo] <= qtheta);
		end else begin
			tsum = {2'b00, lut_theta[lo]} + {2'b00, lut_theta[hi]};
			r.forbidden = (tsum <= {1'b0, qtheta, 1'b0});
		end
		r.exact_match = hit;
		return r;
	endfunction

	// an accepted input transaction updates the table or queues a verdict
	function automatic void take_item(input cbt_pkg::item_t t);
		if (t.kind == cbt_pkg::KIND_WRITE) begin
			lut_phi[t.entry_index] = t.phi_value;
			lut_theta[t.entry_index] = t.theta_value;
			writes_done++;
		end else begin
			expected_verdicts.push_back(lookup_boundary(t.phi_value, t.theta_value));
			queries_sent++;
		end
	endfunction

	function automatic int draw_wait();
		if (calm_phase) return 0;
		if ($urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 19);
	endfunction

	function automatic int rand_phi(input int a, input int b);
		int t;
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		return a + int'($urandom_range(0, b - a));
	endfunction

	function automatic int rand_theta();
		case ($urandom_range(0, 15))
			0: return 0;
			1: return ANGLE_MAX;
			default: return $urandom_range(0, ANGLE_MAX);
		endcase
	endfunction

	function automatic int clamp_theta(input int v);
		if (v < 0) return 0;
		if (v > ANGLE_MAX) return ANGLE_MAX;
		return v;
	endfunction

	task automatic push_write(input int slot, input int phi, input int theta);
		pending_t p;
		p.txn.kind = cbt_pkg::KIND_WRITE;
		p.txn.entry_index = slot[8:0];
		p.txn.phi_value = phi[15:0];
		p.txn.theta_value = theta[14:0];
		p.drain = 1'b0;
		gen_phi[slot] = phi;
		gen_theta[slot] = theta;
		pending_items.push_back(p);
	endtask

	task automatic push_query(input int phi, input int theta, input bit drain);
		pending_t p;
		int       slot;
		slot = $urandom_range(0, DEPTH - 1);
		p.txn.kind = cbt_pkg::KIND_QUERY;
		p.txn.entry_index = slot[8:0];
		p.txn.phi_value = phi[15:0];
		p.txn.theta_value = theta[14:0];
		p.drain = drain;
		pending_items.push_back(p);
	endtask

	// ascending table over the whole angle range, spacing large enough for gaps
	task automatic build_ascending_table();
		for (int i = 0; i < DEPTH; i++) begin
			push_write(i, -23000 + i * 90 + $urandom_range(0, 44), rand_theta());
		end
	endtask

	// random query aimed at hits, gaps, both clamps or anywhere
	task automatic add_random_query(input bit drain);
		int k;
		int phi;
		int around;
		k = 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				k = $urandom_range(0, gen_n - 1);
				phi = gen_phi[k];
				around = gen_theta[k];
			end
			4, 5, 6: begin
				k = $urandom_range(0, gen_n - 2);
				if (gen_phi[k + 1] - gen_phi[k] >= 2 || gen_phi[k] - gen_phi[k + 1] >= 2)
					phi = rand_phi(gen_phi[k] + 1, gen_phi[k + 1] - 1);
				else
					phi = gen_phi[k];
				around = (gen_theta[k] + gen_theta[k + 1]) / 2;
			end
			7: begin
				phi = rand_phi(-ANGLE_MAX, gen_phi[0]);
				around = gen_theta[0];
			end
			8: begin
				phi = rand_phi(gen_phi[gen_n - 1], ANGLE_MAX);
				around = gen_theta[gen_n - 1];
			end
			default: begin
				phi = rand_phi(-ANGLE_MAX, ANGLE_MAX);
				around = $urandom_range(0, ANGLE_MAX);
			end
		endcase
		if ($urandom_range(0, 1) == 0)
			push_query(phi, clamp_theta(around - 2 + $urandom_range(0, 4)), drain);
		else
			push_query(phi, rand_theta(), drain);
	endtask

	// random table write; keeps phi ascending unless order is free
	task automatic add_random_write();
		int slot;
		int lo_b;
		int hi_b;
		int phi;
		slot = $urandom_range(0, DEPTH - 1);
		lo_b = (slot == 0) ? -ANGLE_MAX - 1 : gen_phi[slot - 1];
		hi_b = (slot == DEPTH - 1) ? ANGLE_MAX + 1 : gen_phi[slot + 1];
		if (order_free)
			phi = rand_phi(-ANGLE_MAX, ANGLE_MAX);
		else if (hi_b - lo_b >= 2)
			phi = rand_phi(lo_b + 1, hi_b - 1);
		else
			phi = gen_phi[slot];
		push_write(slot, phi, rand_theta());
	endtask

	// wait until the block has drained everything
	task automatic wait_idle();
		forever begin
			while (pending_items.size() > 0 || item_valid || expected_verdicts.size() > 0)
				@(posedge clk);
			repeat (DRAIN_WAIT) @(posedge clk);
			if (pending_items.size() == 0 && !item_valid && expected_verdicts.size() == 0)
				break;
		end
	endtask

	task automatic set_entry_count(input int v);
		@(posedge clk);
		count_we <= 1'b1;
		count_wdata <= v[9:0];
		@(posedge clk);
		count_we <= 1'b0;
		cfg_count = v[9:0];
		gen_n = v;
		if (gen_n < cbt_pkg::MIN_COUNT) gen_n = cbt_pkg::MIN_COUNT;
		if (gen_n > DEPTH) gen_n = DEPTH;
		count_writes++;
	endtask

	// compare one result transaction with the oldest expected verdict
	task automatic check_verdict(input cbt_pkg::result_t got);
		cbt_pkg::result_t want;
		if (expected_verdicts.size() == 0) begin
			$error("result with no query waiting: forbidden=%0b exact_match=%0b",
				got.forbidden, got.exact_match);
			error_count++;
		end else begin
			want = expected_verdicts.pop_front();
			verdicts_seen++;
			if (want.exact_match) exact_seen++;
			if (want.forbidden) forbid_seen++;
			if (got.forbidden !== want.forbidden) begin
				$error("forbidden: expected %0b, actual %0b", want.forbidden, got.forbidden);
				error_count++;
			end
			if (got.exact_match !== want.exact_match) begin
				$error("exact_match: expected %0b, actual %0b",
					want.exact_match, got.exact_match);
				error_count++;
			end
		end
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			item_gap <= 0;
		end else begin
			drv_valid_nxt = item_valid;
			if (item_valid && !item_stall) begin
				take_item(item);
				drv_valid_nxt = 1'b0;
			end
			if (!drv_valid_nxt) begin
				if (item_gap > 0) begin
					item_gap <= item_gap - 1;
				end else if (pending_items.size() > 0 &&
						!(pending_items[0].drain && expected_verdicts.size() > 0)) begin
					drv_pick = pending_items.pop_front();
					item <= drv_pick.txn;
					item_gap <= draw_wait();
					drv_valid_nxt = 1'b1;
				end
			end
			item_valid <= drv_valid_nxt;
		end
	end

	// result monitor with random stall per transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (result_valid && !result_stall) begin
			check_verdict(result);
			mon_wait = draw_wait();
			stall_left <= mon_wait;
			result_stall <= (mon_wait != 0);
		end else if (result_valid && stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= (stall_left > 1);
		end
	end

	// cycles without any transaction
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || count_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("cone_boundary_table_check_top_tb: done, errors");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int v;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whole table first, then lookups at the reset count
		build_ascending_table();
		// entries with controlled thetas for the midpoint comparison
		push_write(100, gen_phi[100], 1000);
		push_write(101, gen_phi[101], 1001);
		push_write(200, gen_phi[200], 5000);
		push_write(201, gen_phi[201], 5002);
		push_write(50, gen_phi[50], ANGLE_MAX);
		push_write(51, gen_phi[51], ANGLE_MAX);
		push_write(10, gen_phi[10], 0);
		// below the table, on entry 0, on the last valid entry, above it
		push_query(-ANGLE_MAX, 0, 1'b0);
		push_query(gen_phi[0], ANGLE_MAX, 1'b0);
		push_query(gen_phi[360], gen_theta[360], 1'b0);
		push_query(ANGLE_MAX, ANGLE_MAX, 1'b0);
		push_query(gen_phi[361], 0, 1'b0);
		// hit on the first probe
		push_query(gen_phi[180], gen_theta[180], 1'b0);
		// odd sum: one below and one at the ceiling of the mean
		push_query(gen_phi[100] + 3, 1000, 1'b0);
		push_query(gen_phi[100] + 3, 1001, 1'b0);
		// even sum: mean itself and one below
		push_query(gen_phi[201] - 3, 5001, 1'b0);
		push_query(gen_phi[201] - 3, 5000, 1'b0);
		// theta extremes
		push_query(gen_phi[50] + 5, ANGLE_MAX, 1'b0);
		push_query(gen_phi[50] + 5, ANGLE_MAX - 1, 1'b0);
		push_query(gen_phi[10], 0, 1'b0);
		wait_idle();

		for (int ph = 0; ph < PLAN_LEN; ph++) begin
			v = COUNT_PLAN[ph];
			if (ph == RANDOM_PH) v = $urandom_range(4, DEPTH - 1);
			set_entry_count(v);
			calm_phase = (ph % 4 == 2);
			order_free = (ph == SCRAMBLE_PH);
			// table out of order over the active entries
			if (order_free) begin
				for (int i = 0; i < gen_n; i++)
					push_write(i, rand_phi(-ANGLE_MAX, ANGLE_MAX), rand_theta());
			end
			// both ends and the first gap at this count
			push_query(gen_phi[0], rand_theta(), 1'b0);
			push_query(gen_phi[gen_n - 1], rand_theta(), 1'b0);
			push_query(-ANGLE_MAX, rand_theta(), 1'b0);
			push_query(ANGLE_MAX, rand_theta(), 1'b0);
			push_query(rand_phi(gen_phi[0], gen_phi[1]),
				(gen_theta[0] + gen_theta[1]) / 2, 1'b0);
			for (int r = 0; r < PHASE_ITEMS; r++) begin
				if ($urandom_range(0, 4) == 0)
					add_random_write();
				else
					add_random_query((r == 10) || ($urandom_range(0, 49) == 0));
			end
			wait_idle();
		end

		wait_idle();
		$display("covered %0d queries and %0d table writes over %0d entry count settings",
			queries_sent, writes_done, count_writes);
		$display("checked %0d verdicts: %0d exact hits, %0d forbidden",
			verdicts_seen, exact_seen, forbid_seen);
		if (error_count == 0 && expected_verdicts.size() == 0) begin
			$display("cone_boundary_table_check_top_tb: done, clean");
		end else begin
			$display("cone_boundary_table_check_top_tb: done, errors");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/cbt_pkg.sv
rtl/cbt_table_ram.sv
rtl/cbt_search.sv
rtl/cone_boundary_table_check_top.sv
rtl/cbt_checker.sv
tb/cone_boundary_table_check_top_tb.sv
